// ===== rtl/core/dcsr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcsr_pkg
// Shared types and constants for the dot canvas shape rasterizer.
// ----------------------------------------------------------------------------
package dcsr_pkg;

    // Canvas geometry
    localparam int WIDTH  = 256;
    localparam int HEIGHT = 64;
    localparam int NPIX   = WIDTH * HEIGHT;
    localparam int CX     = WIDTH / 2;
    localparam int CY     = HEIGHT / 2;

    localparam int COL_W  = $clog2(WIDTH);
    localparam int ROW_W  = $clog2(HEIGHT);
    localparam int ADDR_W = $clog2(NPIX);

    // Field widths of a command transaction
    localparam int CMD_W   = 3;
    localparam int POS_W   = 11;
    localparam int RAD_W   = 10;
    localparam int SLOPE_W = 9;
    localparam int OFS_W   = 11;
    localparam int RROW_W  = 6;
    localparam int RCOL_W  = 8;

    // Datapath widths, sized for canvas sides up to 1024
    localparam int D_W   = 12;           // signed circle deltas and row distance
    localparam int SQ_W  = 2 * D_W;      // squared delta
    localparam int RSQ_W = 2 * RAD_W;    // squared radius
    localparam int L_W   = 11;           // signed column distance for the line
    localparam int LP_W  = 20;           // signed line product plus offset

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR  = 3'd0,
        CMD_AXES   = 3'd1,
        CMD_CIRCLE = 3'd2,
        CMD_LINE   = 3'd3,
        CMD_READ   = 3'd4
    } t_cmd;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_INIT_DRAIN,
        ST_IDLE,
        ST_SWEEP,
        ST_DRAIN,
        ST_DONE
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic load;        // latch operands of an accepted transaction
        logic rd_req;      // read one pixel at the requested place
        logic sweep_init;  // rewind the pixel counters
        logic run;         // issue one pixel into the pipeline
        logic out_load;    // place the result in the output register
    } t_dp_ctl;

    // Datapath to controller
    typedef struct packed {
        logic sweep_last;  // counters sit on the last pixel
        logic pipe_empty;  // no pixel left in flight
        logic out_free;    // output register can take a result
    } t_dp_sts;

endpackage

// ===== rtl/core/dot_canvas_shape_rasterizer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dot_canvas_shape_rasterizer_unit
// One-bit dot canvas that clears, draws axes, circles and lines, and reads
// single pixels; one result transaction per command transaction.
// ----------------------------------------------------------------------------
//
//  channel   handshake                   payload
//  -------   -------------------------   ---------------------------------------
//  command   i_in_valid / o_in_stall     i_cmd, i_circ_x, i_circ_y, i_radius,
//                                        i_slope, i_offset, i_row, i_col
//  result    o_out_valid / i_out_stall   o_pixel
//
//  Clear, axes, circle and line walk all WIDTH*HEIGHT pixels at one pixel per
//  cycle through a three-stage hit pipeline; the result is loaded into the
//  output register once the pipeline has drained, and the next command is
//  taken when the unit is back in idle. Read and unknown commands skip the
//  sweep and go straight to the result state. The pixel sweep sets the rate.
//  After reset a clearing pass over all WIDTH*HEIGHT pixels runs before the
//  first command is taken. One command is in flight at a time; a stalled
//  result holds the unit in its result state.
//
module dot_canvas_shape_rasterizer_unit
    import dcsr_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [CMD_W-1:0]          i_cmd,
    input  logic signed [POS_W-1:0]   i_circ_x,
    input  logic signed [POS_W-1:0]   i_circ_y,
    input  logic [RAD_W-1:0]          i_radius,
    input  logic signed [SLOPE_W-1:0] i_slope,
    input  logic signed [OFS_W-1:0]   i_offset,
    input  logic [RROW_W-1:0]         i_row,
    input  logic [RCOL_W-1:0]         i_col,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic                      o_pixel
);

    t_dp_ctl ctl;
    t_dp_sts sts;

    dcsr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_cmd      (i_cmd),
        .i_sts      (sts),
        .o_in_stall (o_in_stall),
        .o_ctl      (ctl)
    );

    dcsr_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .o_sts       (sts),
        .i_cmd       (i_cmd),
        .i_circ_x    (i_circ_x),
        .i_circ_y    (i_circ_y),
        .i_radius    (i_radius),
        .i_slope     (i_slope),
        .i_offset    (i_offset),
        .i_row       (i_row),
        .i_col       (i_col),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_pixel     (o_pixel)
    );

endmodule

// ===== rtl/core/dcsr_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcsr_ctrl
// Sequencer: reset clearing pass, command dispatch, sweep, drain and result.
// ----------------------------------------------------------------------------
module dcsr_ctrl
    import dcsr_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic [CMD_W-1:0] i_cmd,
    input  t_dp_sts          i_sts,
    output logic             o_in_stall,
    output t_dp_ctl          o_ctl
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_INIT: begin
                if (i_sts.sweep_last) begin
                    n_state = ST_INIT_DRAIN;
                end
            end
            ST_INIT_DRAIN: begin
                if (i_sts.pipe_empty) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_cmd == CMD_CLEAR || i_cmd == CMD_AXES ||
                        i_cmd == CMD_CIRCLE || i_cmd == CMD_LINE) begin
                        n_state = ST_SWEEP;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_SWEEP: begin
                if (i_sts.sweep_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (i_sts.pipe_empty) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_sts.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_INIT;
        endcase
    end

    always_comb begin
        o_ctl      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            ST_INIT: begin
                o_ctl.run = 1'b1;
            end
            ST_INIT_DRAIN: begin
            end
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_ctl.load       = 1'b1;
                    o_ctl.sweep_init = 1'b1;
                    o_ctl.rd_req     = (i_cmd == CMD_READ);
                end
            end
            ST_SWEEP: begin
                o_ctl.run = 1'b1;
            end
            ST_DRAIN: begin
            end
            ST_DONE: begin
                o_ctl.out_load = i_sts.out_free;
            end
            default: begin
            end
        endcase
    end

endmodule

// ===== rtl/core/dcsr_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcsr_datapath
// Canvas memory, pixel sweep counters, three-stage hit pipeline and the
// output register.
// ----------------------------------------------------------------------------
module dcsr_datapath
    import dcsr_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_dp_ctl                   i_ctl,
    output t_dp_sts                   o_sts,
    input  logic [CMD_W-1:0]          i_cmd,
    input  logic signed [POS_W-1:0]   i_circ_x,
    input  logic signed [POS_W-1:0]   i_circ_y,
    input  logic [RAD_W-1:0]          i_radius,
    input  logic signed [SLOPE_W-1:0] i_slope,
    input  logic signed [OFS_W-1:0]   i_offset,
    input  logic [RROW_W-1:0]         i_row,
    input  logic [RCOL_W-1:0]         i_col,
    input  logic                      i_out_stall,
    output logic                      o_out_valid,
    output logic                      o_pixel
);

    // Operands of the current transaction
    logic [CMD_W-1:0]          r_op;
    logic signed [POS_W-1:0]   r_ox;
    logic signed [POS_W-1:0]   r_oy;
    logic [RSQ_W-1:0]          r_rad_sq;
    logic signed [SLOPE_W-1:0] r_k;
    logic signed [OFS_W-1:0]   r_b;
    logic                      r_rd_ok;

    // Sweep counters
    logic [ROW_W-1:0]  r_row;
    logic [COL_W-1:0]  r_col;
    logic [ADDR_W-1:0] r_addr;

    // Stage 1: deltas
    logic                  r_s1_valid;
    logic [ADDR_W-1:0]     r_s1_addr;
    logic signed [D_W-1:0] r_s1_dx;
    logic signed [D_W-1:0] r_s1_dy;
    logic signed [L_W-1:0] r_s1_ldif;
    logic signed [D_W-1:0] r_s1_dr;
    logic                  r_s1_axes;

    // Stage 2: products
    logic                   r_s2_valid;
    logic [ADDR_W-1:0]      r_s2_addr;
    logic [SQ_W-1:0]        r_s2_sqx;
    logic [SQ_W-1:0]        r_s2_sqy;
    logic signed [LP_W-1:0] r_s2_prod;
    logic signed [D_W-1:0]  r_s2_dr;
    logic                   r_s2_axes;

    // Canvas and read port
    logic              r_mem [NPIX];
    logic              r_rd_data;
    logic [ADDR_W-1:0] rd_addr;

    logic              hit;
    logic              wr_en;
    logic              wr_data;
    logic [SQ_W:0]     dist_sq;

    logic r_out_valid;
    logic r_out_pixel;

    // Operand capture
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op <= CMD_CLEAR;
        end else if (i_ctl.load) begin
            r_op <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_ox     <= i_circ_x;
            r_oy     <= i_circ_y;
            r_rad_sq <= RSQ_W'(i_radius) * RSQ_W'(i_radius);
            r_k      <= i_slope;
            r_b      <= i_offset;
            r_rd_ok  <= (32'(i_row) < HEIGHT) && (32'(i_col) < WIDTH);
        end
    end

    // Walk the canvas in row-major order, one pixel per cycle while run is asserted
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row  <= '0;
            r_col  <= '0;
            r_addr <= '0;
        end else if (i_ctl.sweep_init) begin
            r_row  <= '0;
            r_col  <= '0;
            r_addr <= '0;
        end else if (i_ctl.run) begin
            r_addr <= r_addr + 1'b1;
            if (r_col == COL_W'(WIDTH - 1)) begin
                r_col <= '0;
                r_row <= r_row + 1'b1;
            end else begin
                r_col <= r_col + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_ctl.run;
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_addr <= r_addr;
        r_s1_dx   <= D_W'(r_col) - D_W'(CX) - D_W'(r_ox);
        r_s1_dy   <= D_W'(r_row) - D_W'(CY) + D_W'(r_oy);
        r_s1_ldif <= L_W'(CX) - L_W'(r_col);
        r_s1_dr   <= D_W'(r_row) - D_W'(CY);
        r_s1_axes <= (r_row == ROW_W'(CY)) || (r_col == COL_W'(CX));

        r_s2_addr <= r_s1_addr;
        r_s2_sqx  <= SQ_W'(r_s1_dx) * SQ_W'(r_s1_dx);
        r_s2_sqy  <= SQ_W'(r_s1_dy) * SQ_W'(r_s1_dy);
        r_s2_prod <= LP_W'(r_k) * LP_W'(r_s1_ldif);
        r_s2_dr   <= r_s1_dr;
        r_s2_axes <= r_s1_axes;
    end

    // Stage 3: decide and write
    assign dist_sq = {1'b0, r_s2_sqx} + {1'b0, r_s2_sqy};

    always_comb begin
        unique case (r_op)
            CMD_AXES:   hit = r_s2_axes;
            CMD_CIRCLE: hit = (dist_sq <= (SQ_W + 1)'(r_rad_sq));
            CMD_LINE:   hit = ((r_s2_prod + LP_W'(r_b)) == LP_W'(r_s2_dr));
            default:    hit = 1'b1;
        endcase
    end

    // Clear writes blanks everywhere; drawing only sets dots
    assign wr_en   = r_s2_valid && hit;
    assign wr_data = (r_op != CMD_CLEAR);
    assign rd_addr = ADDR_W'(ADDR_W'(i_row) * ADDR_W'(WIDTH)) + ADDR_W'(i_col);

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_s2_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_req) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctl.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.out_load) begin
            r_out_pixel <= (r_op == CMD_READ) && r_rd_ok && r_rd_data;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_pixel          = r_out_pixel;
    assign o_sts.sweep_last = (r_addr == ADDR_W'(NPIX - 1));
    assign o_sts.pipe_empty = !r_s1_valid && !r_s2_valid;
    assign o_sts.out_free   = !r_out_valid || !i_out_stall;

endmodule
